/* rtl/core/twes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twes_pkg
// Shared types and constants of the time-window event surface.
// ----------------------------------------------------------------------------
package twes_pkg;

  localparam int unsigned COORD_W    = 7;
  localparam int unsigned STAMP_W    = 24;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned CAUSE_W    = 2;
  localparam int unsigned ENTRY_W    = 2 * COORD_W + STAMP_W;
  localparam int unsigned RES_W      = CAUSE_W + ENTRY_W;
  localparam int unsigned RES_DEPTH  = 64;
  localparam int unsigned RES_AW     = 6;
  localparam int unsigned RES_CNT_W  = 7;

  localparam logic [STAMP_W-1:0] DURATION_RESET = 24'd100000;

  localparam logic [CAUSE_W-1:0] CAUSE_EXPIRED  = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_REPLACED = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_OWN,
    S_CHK,
    S_PUSH,
    S_PUSH_CHK,
    S_REPL,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_e;

  typedef enum logic [1:0] {
    PH_FRONT,
    PH_BACK,
    PH_FULL
  } phase_e;

endpackage
`default_nettype wire

/* rtl/core/twes_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twes_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module twes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/twes_expiry.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twes_expiry
// Window compare: flags a stored stamp outside the wrapping window.
// ----------------------------------------------------------------------------
module twes_expiry
  import twes_pkg::*;
#(
  parameter int unsigned STAMP_WRAP = 32'd16777215
) (
  input  wire logic [STAMP_W-1:0] stored_i,
  input  wire logic [STAMP_W-1:0] current_i,
  input  wire logic [STAMP_W-1:0] duration_i,
  output logic                    expired_o
);

  localparam int unsigned CW = 34;

  logic [CW-1:0] vd;
  logic [CW-1:0] cur;
  logic [CW-1:0] upper;

  // v < c - d  <=>  v + d < c ;  v < c + wrap - d  <=>  v + d < c + wrap
  always_comb begin
    vd        = CW'(stored_i) + CW'(duration_i);
    cur       = CW'(current_i);
    upper     = cur + CW'(STAMP_WRAP);
    expired_o = ((stored_i > current_i) && (vd < upper)) || (vd < cur);
  end

endmodule
`default_nettype wire

/* rtl/core/temporal_window_event_surface_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// temporal_window_event_surface_unit
// Time-ordered event ring with per-pixel owner map; reports expired,
// replaced and overflowed events for each incoming pixel event.
// ----------------------------------------------------------------------------
// Per item: an accept step; per ring entry inspected, a ring read, an owner
// read and a compare/update; a check whenever the ring is empty; the push
// plus a replacement step when the pixel had an owner; then per result beat
// a result read, output load and wait (no read for the no-removal beat),
// plus output stall. One item in flight. Reset: control cleared at once, then
// a clearing pass over all SENSOR_WIDTH*SENSOR_HEIGHT owner entries, in_stall_o high.
module temporal_window_event_surface_unit
  import twes_pkg::*;
#(
  parameter int unsigned SENSOR_WIDTH  = 128,
  parameter int unsigned SENSOR_HEIGHT = 128,
  parameter int unsigned RING_DEPTH    = 32,
  parameter int unsigned STAMP_WRAP    = 32'd16777215
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [STAMP_W-1:0] cfg_window_duration_i,

  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [COORD_W-1:0] pixel_x_i,
  input  wire logic [COORD_W-1:0] pixel_y_i,
  input  wire logic [STAMP_W-1:0] event_stamp_i,

  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    removed_valid_o,
  output logic [CAUSE_W-1:0]      removal_cause_o,
  output logic [COORD_W-1:0]      removed_x_o,
  output logic [COORD_W-1:0]      removed_y_o,
  output logic [STAMP_W-1:0]      removed_stamp_o,
  output logic [COUNT_W-1:0]      active_events_o,
  output logic                    last_result_o
);

  localparam int unsigned PIX      = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int unsigned PIX_W    = $clog2(PIX);
  localparam int unsigned SLOT_W   = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W   = $clog2(RING_DEPTH + 1);
  localparam int unsigned OWN_W    = SLOT_W + 1;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
  localparam logic [PIX_W-1:0]  PIX_LAST  = PIX_W'(PIX - 1);

  function automatic logic [PIX_W-1:0] pix_index(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
    return PIX_W'(32'(y) * SENSOR_WIDTH + 32'(x));
  endfunction

  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [FILL_W:0] sum);
    logic [FILL_W:0] t;
    t = (sum >= (FILL_W+1)'(RING_DEPTH)) ? sum - (FILL_W+1)'(RING_DEPTH) : sum;
    return t[SLOT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // registers
  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [SLOT_W-1:0]    head_q, head_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [COUNT_W-1:0]   live_q, live_d;
  logic [STAMP_W-1:0]   dur_q;
  logic [PIX_W-1:0]     clr_q, clr_d;
  logic [RES_CNT_W-1:0] n_q, n_d;
  logic [RES_CNT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic [PIX_W-1:0]     pix_q, pix_d;
  logic [COORD_W-1:0]   x_q, y_q;
  logic [STAMP_W-1:0]   c_q;
  logic                 out_valid_q, out_valid_d;
  logic                 rv_q, last_q;
  logic [CAUSE_W-1:0]   cause_q;
  logic [COORD_W-1:0]   ox_q, oy_q;
  logic [STAMP_W-1:0]   ot_q;
  logic                 load_out, load_zero;

  // RAM ports
  logic                 ring_we, ring_re;
  logic [SLOT_W-1:0]    ring_waddr, ring_raddr;
  logic [ENTRY_W-1:0]   ring_wdata, ring_rd;
  logic                 own_we, own_re;
  logic [PIX_W-1:0]     own_waddr, own_raddr;
  logic [OWN_W-1:0]     own_wdata, own_rd;
  logic                 res_we, res_re;
  logic [RES_W-1:0]     res_wdata, res_rd;

  logic [COORD_W-1:0]   ent_x, ent_y;
  logic [STAMP_W-1:0]   ent_t;
  logic                 expired, live, in_range, accept;
  logic [SLOT_W-1:0]    head_inc, tail_slot, push_slot;
  logic [CAUSE_W-1:0]   rec_cause;
  logic                 rec;

  assign {ent_x, ent_y, ent_t} = ring_rd;

  twes_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rd)
  );

  twes_ram #(.WIDTH(OWN_W), .DEPTH(PIX)) u_owner (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .re_i    (own_re),
    .raddr_i (own_raddr),
    .rdata_o (own_rd)
  );

  twes_ram #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_results (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (n_q[RES_AW-1:0]),
    .wdata_i (res_wdata),
    .re_i    (res_re),
    .raddr_i (idx_q[RES_AW-1:0]),
    .rdata_o (res_rd)
  );

  twes_expiry #(.STAMP_WRAP(STAMP_WRAP)) u_expiry (
    .stored_i   (ent_t),
    .current_i  (c_q),
    .duration_i (dur_q),
    .expired_o  (expired)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign in_range    = (32'(pixel_x_i) < SENSOR_WIDTH) && (32'(pixel_y_i) < SENSOR_HEIGHT);

  assign head_inc  = slot_wrap((FILL_W+1)'(head_q) + (FILL_W+1)'(1));
  assign tail_slot = slot_wrap((FILL_W+1)'(head_q) + (FILL_W+1)'(fill_q) - (FILL_W+1)'(1));
  assign push_slot = slot_wrap((FILL_W+1)'(head_q) + (FILL_W+1)'(fill_q));
  assign live      = own_rd[OWN_W-1] && (own_rd[SLOT_W-1:0] == cur_q);

  // --------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    head_d      = head_q;
    fill_d      = fill_q;
    live_d      = live_q;
    clr_d       = clr_q;
    n_d         = n_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    pix_d       = pix_q;
    out_valid_d = out_valid_q;
    load_out    = 1'b0;
    load_zero   = 1'b0;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    ring_waddr  = push_slot;
    ring_wdata  = {x_q, y_q, c_q};
    own_we      = 1'b0;
    own_re      = 1'b0;
    own_waddr   = pix_q;
    own_wdata   = '0;
    own_raddr   = pix_index(ent_x, ent_y);
    res_re      = 1'b0;
    rec         = 1'b0;
    rec_cause   = CAUSE_EXPIRED;

    unique case (state_q)
      S_CLEAR: begin
        own_we    = 1'b1;
        own_waddr = clr_q;
        if (clr_q == PIX_LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + PIX_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          n_d     = '0;
          idx_d   = '0;
          phase_d = PH_FRONT;
          state_d = in_range ? S_RD : S_EMIT_RD;
        end
      end
      S_RD: begin
        case (phase_q)
          PH_FRONT: begin
            if (fill_q == '0) begin
              phase_d = PH_BACK;
            end else begin
              cur_d   = head_q;
              ring_re = 1'b1;
              state_d = S_OWN;
            end
          end
          PH_BACK: begin
            if (fill_q == '0) begin
              state_d = S_PUSH;
            end else begin
              cur_d   = tail_slot;
              ring_re = 1'b1;
              state_d = S_OWN;
            end
          end
          default: begin
            cur_d   = head_q;
            ring_re = 1'b1;
            state_d = S_OWN;
          end
        endcase
      end
      S_OWN: begin
        own_re  = 1'b1;
        pix_d   = pix_index(ent_x, ent_y);
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = S_RD;
        case (phase_q)
          PH_FRONT: begin
            if (live && !expired) begin
              phase_d = PH_BACK;
            end else begin
              rec    = live;
              head_d = head_inc;
              fill_d = fill_q - FILL_W'(1);
            end
          end
          PH_BACK: begin
            if (live && !expired) begin
              if (fill_q == FILL_FULL) begin
                phase_d = PH_FULL;
              end else begin
                state_d = S_PUSH;
              end
            end else begin
              rec    = live;
              fill_d = fill_q - FILL_W'(1);
            end
          end
          default: begin
            rec       = live;
            rec_cause = CAUSE_OVERFLOW;
            head_d    = head_inc;
            fill_d    = fill_q - FILL_W'(1);
            state_d   = S_PUSH;
          end
        endcase
        if (rec) begin
          own_we    = 1'b1;
          own_waddr = pix_q;
          if (live_q != '0) begin
            live_d = live_q - COUNT_W'(1);
          end
        end
      end
      S_PUSH: begin
        ring_we   = 1'b1;
        own_re    = 1'b1;
        own_raddr = pix_index(x_q, y_q);
        pix_d     = pix_index(x_q, y_q);
        state_d   = S_PUSH_CHK;
      end
      S_PUSH_CHK: begin
        own_we    = 1'b1;
        own_wdata = {1'b1, push_slot};
        fill_d    = fill_q + FILL_W'(1);
        if (own_rd[OWN_W-1]) begin
          cur_d   = own_rd[SLOT_W-1:0];
          ring_re = 1'b1;
          state_d = S_REPL;
        end else begin
          live_d  = live_q + COUNT_W'(1);
          state_d = S_EMIT_RD;
        end
      end
      S_REPL: begin
        rec       = 1'b1;
        rec_cause = CAUSE_REPLACED;
        state_d   = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        if (n_q == '0) begin
          load_zero   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_EMIT_WAIT;
        end else begin
          res_re  = 1'b1;
          state_d = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          idx_d       = idx_q + RES_CNT_W'(1);
          state_d     = (idx_q + RES_CNT_W'(1) >= n_q) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // read address follows the slot chosen this cycle
    ring_raddr = cur_d;
    res_we     = rec && (n_q < RES_CNT_W'(RES_DEPTH));
    res_wdata  = {rec_cause, ring_rd};
    if (res_we) begin
      n_d = n_q + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= PH_FRONT;
      head_q      <= '0;
      fill_q      <= '0;
      live_q      <= '0;
      dur_q       <= DURATION_RESET;
      clr_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      live_q      <= live_d;
      clr_q       <= clr_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dur_q <= cfg_window_duration_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pix_q <= pix_d;
    if (accept) begin
      x_q <= pixel_x_i;
      y_q <= pixel_y_i;
      c_q <= event_stamp_i;
    end
    if (load_zero) begin
      rv_q    <= 1'b0;
      cause_q <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
      ot_q    <= '0;
      last_q  <= 1'b1;
    end else if (load_out) begin
      rv_q                         <= 1'b1;
      {cause_q, ox_q, oy_q, ot_q}  <= res_rd;
      last_q                       <= (idx_q + RES_CNT_W'(1) == n_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_valid_o = rv_q;
  assign removal_cause_o = cause_q;
  assign removed_x_o     = ox_q;
  assign removed_y_o     = oy_q;
  assign removed_stamp_o = ot_q;
  assign active_events_o = live_q;
  assign last_result_o   = last_q;

  // --------------------------------------------------------------------------
  // assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("ring fill above depth");

  a_live_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FILL_W'(live_q) <= fill_q)
    else $error("live count above ring fill");

  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_EMIT_WAIT))
    else $error("result beat outside emit");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= RES_CNT_W'(RING_DEPTH + 1))
    else $error("too many results for one event");

endmodule
`default_nettype wire

/* tb/temporal_window_event_surface_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// temporal_window_event_surface_unit_tb
// Drives pixel events in random bursts. A local model of the event ring and
// the pixel owner map predicts every result beat: expired, replaced and
// overflowed events. Each beat is checked field by field. The window length
// is changed between phases, including the zero and full-range settings.
// ----------------------------------------------------------------------------
module temporal_window_event_surface_unit_tb;
  import twes_pkg::*;

  localparam int unsigned RING_N    = 32;
  localparam int unsigned PIX_N     = 128 * 128;
  localparam longint      WRAP      = 64'd16777215;
  localparam int unsigned CYC_LIMIT = 1000000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [STAMP_W-1:0] t;
  } pix_event_t;

  typedef struct packed {
    logic               rv;
    logic [CAUSE_W-1:0] cause;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [STAMP_W-1:0] t;
    logic [COUNT_W-1:0] cnt;
    logic               last;
  } removal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [STAMP_W-1:0] cfg_window_duration_i = '0;
  logic in_valid_i = 1'b0;
  logic [COORD_W-1:0] pixel_x_i = '0;
  logic [COORD_W-1:0] pixel_y_i = '0;
  logic [STAMP_W-1:0] event_stamp_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_ready_o, in_stall_o, out_valid_o;
  logic removed_valid_o, last_result_o;
  logic [CAUSE_W-1:0] removal_cause_o;
  logic [COORD_W-1:0] removed_x_o, removed_y_o;
  logic [STAMP_W-1:0] removed_stamp_o;
  logic [COUNT_W-1:0] active_events_o;

  temporal_window_event_surface_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_window_duration_i,
    .in_valid_i, .in_stall_o, .pixel_x_i, .pixel_y_i, .event_stamp_i,
    .out_valid_o, .out_stall_i, .removed_valid_o, .removal_cause_o,
    .removed_x_o, .removed_y_o, .removed_stamp_o, .active_events_o,
    .last_result_o
  );

  always #10 clk_i = ~clk_i;

  // surface model state
  pix_event_t         ring_q[RING_N];
  int unsigned        head, fill, live;
  bit                 own_v[PIX_N];
  logic [4:0]         own_s[PIX_N];
  logic [STAMP_W-1:0] window_len = DURATION_RESET;

  pix_event_t  pending_q[$];
  removal_t    removal_q[$];
  int unsigned errors = 0, events_sent = 0, beats_seen = 0, cycles = 0;
  int unsigned n_expired = 0, n_replaced = 0, n_overflow = 0;

  function automatic bit slot_live(int unsigned s);
    int unsigned p;
    p = {ring_q[s].y, ring_q[s].x};
    return own_v[p] && own_s[p] == s[4:0];
  endfunction

  function automatic bit out_of_window(longint v, longint c);
    longint d;
    d = longint'(window_len);
    return (v > c && v < c + WRAP - d) || v < c - d;
  endfunction

  function automatic void note_removal(ref removal_t acc[$], input logic [1:0] cause,
                                       input int unsigned s);
    removal_t r;
    r = '0;
    r.rv = 1'b1;
    r.cause = cause;
    r.x = ring_q[s].x;
    r.y = ring_q[s].y;
    r.t = ring_q[s].t;
    acc = {acc, r};
    if (cause == CAUSE_EXPIRED) n_expired++;
    else if (cause == CAUSE_REPLACED) n_replaced++;
    else n_overflow++;
  endfunction

  function automatic void retire(int unsigned s);
    own_v[{ring_q[s].y, ring_q[s].x}] = 1'b0;
    if (live > 0) live--;
  endfunction

  function automatic void predict_event(pix_event_t ev);
    removal_t    acc[$];
    removal_t    r;
    int unsigned s, p;
    // oldest end
    while (fill > 0) begin
      s = head;
      if (slot_live(s) && !out_of_window(ring_q[s].t, ev.t)) break;
      if (slot_live(s)) begin
        note_removal(acc, CAUSE_EXPIRED, s);
        retire(s);
      end
      head = (head + 1) % RING_N;
      fill--;
    end
    // newest end
    while (fill > 0) begin
      s = (head + fill - 1) % RING_N;
      if (slot_live(s) && !out_of_window(ring_q[s].t, ev.t)) break;
      if (slot_live(s)) begin
        note_removal(acc, CAUSE_EXPIRED, s);
        retire(s);
      end
      fill--;
    end
    if (fill >= RING_N) begin
      s = head;
      if (slot_live(s)) begin
        note_removal(acc, CAUSE_OVERFLOW, s);
        retire(s);
      end
      head = (head + 1) % RING_N;
      fill--;
    end
    s = (head + fill) % RING_N;
    ring_q[s] = ev;
    fill++;
    p = {ev.y, ev.x};
    if (own_v[p]) note_removal(acc, CAUSE_REPLACED, own_s[p]);
    else live++;
    own_v[p] = 1'b1;
    own_s[p] = s[4:0];
    if (acc.size() == 0) begin
      r = '0;
      acc = {acc, r};
    end
    foreach (acc[k]) begin
      r = acc[k];
      r.cnt = live[COUNT_W-1:0];
      r.last = (k == acc.size() - 1);
      removal_q = {removal_q, r};
    end
  endfunction

  // sender: bursts with gaps
  int unsigned burst_left = 4, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic       next_valid;
    pix_event_t ev;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_event({pixel_x_i, pixel_y_i, event_stamp_i});
        events_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          ev = pending_q[0];
          pending_q.delete(0);
          pixel_x_i <= ev.x;
          pixel_y_i <= ev.y;
          event_stamp_i <= ev.t;
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // receiver: stall mode rotates through four patterns
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    case ((cycles / 300) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((cycles % 7) < 3);
    endcase
    if (cycles > CYC_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $realtime, removal_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    removal_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      got = {removed_valid_o, removal_cause_o, removed_x_o, removed_y_o,
             removed_stamp_o, active_events_o, last_result_o};
      if (removal_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat exp none got %h", $realtime, got);
      end else begin
        want = removal_q[0];
        removal_q.delete(0);
        if (got.rv !== want.rv) begin
          errors++;
          $display("%0t: removed_valid exp %0d got %0d", $realtime, want.rv, got.rv);
        end
        if (got.cause !== want.cause) begin
          errors++;
          $display("%0t: removal_cause exp %0d got %0d", $realtime, want.cause, got.cause);
        end
        if (got.x !== want.x) begin
          errors++;
          $display("%0t: removed_x exp %0d got %0d", $realtime, want.x, got.x);
        end
        if (got.y !== want.y) begin
          errors++;
          $display("%0t: removed_y exp %0d got %0d", $realtime, want.y, got.y);
        end
        if (got.t !== want.t) begin
          errors++;
          $display("%0t: removed_stamp exp %0d got %0d", $realtime, want.t, got.t);
        end
        if (got.cnt !== want.cnt) begin
          errors++;
          $display("%0t: active_events exp %0d got %0d", $realtime, want.cnt, got.cnt);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last_result exp %0d got %0d", $realtime, want.last, got.last);
        end
      end
    end
  end

  task automatic push_event(int unsigned x, int unsigned y, int unsigned t);
    pix_event_t ev;
    ev.x = x[COORD_W-1:0];
    ev.y = y[COORD_W-1:0];
    ev.t = t[STAMP_W-1:0];
    pending_q = {pending_q, ev};
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || removal_q.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_window(logic [STAMP_W-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_window_duration_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    window_len = d;
    cfg_valid_i <= 1'b0;
  endtask

  // random events: mostly in-window flow with some jumps, half on 16 hot pixels
  task automatic random_phase(int unsigned n, int unsigned step_max);
    int unsigned t;
    t = $urandom_range(0, 24'hFFFFFF);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: t = $urandom_range(0, 24'hFFFFFF);
        1: t = t - $urandom_range(0, step_max);
        default: t = t + $urandom_range(0, step_max);
      endcase
      if ($urandom_range(0, 1))
        push_event($urandom_range(0, 3) * 42, $urandom_range(0, 3) * 42, t);
      else
        push_event($urandom_range(0, 127), $urandom_range(0, 127), t);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < PIX_N; i++) own_v[i] = 1'b0;
    head = 0;
    fill = 0;
    live = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default window: extremes, replacement, expiry, stamp wrap
    push_event(0, 0, 0);
    push_event(127, 127, 24'hFFFFFF);
    push_event(0, 0, 10);
    push_event(127, 0, 50000);
    push_event(0, 127, 99999);
    push_event(5, 5, 300000);
    push_event(6, 6, 24'hFFFFF0);
    push_event(7, 7, 20);
    push_event(6, 6, 24'h0F0000);
    drain();

    // zero window: only equal stamps survive
    set_window('0);
    push_event(1, 2, 500);
    push_event(3, 4, 500);
    push_event(3, 4, 501);
    drain();

    // full window: nothing expires, ring overflows
    set_window(24'hFFFFFF);
    for (int i = 0; i < 36; i++) push_event(i, 127 - i, i * 3);
    push_event(34, 93, 200);
    drain();

    set_window(24'd2000);
    random_phase(50, 600);
    set_window(24'd150);
    random_phase(50, 100);
    set_window(DURATION_RESET);
    random_phase(50, 20000);

    $display("events %0d, beats %0d: expired %0d, replaced %0d, overflow %0d",
             events_sent, beats_seen, n_expired, n_replaced, n_overflow);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
